[rtl/msas_pkg.sv]
// Shared types, codes and defaults of the multi-slot alarm scheduler.
package msas_pkg;

    // Default sizing, handed down from the top level
    localparam int DEFAULT_SLOTS       = 8;
    localparam int DEFAULT_ACTION_BITS = 8;
    localparam int DEFAULT_TIME_BITS   = 32;

    // Fixed field widths on the channels
    localparam int COMMAND_W   = 2;
    localparam int ACTION_ID_W = 8;
    localparam int DELAY_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 3;
    localparam int MASK_W      = 8;
    localparam int NOW_W       = 32;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_SCHEDULE = 2'd0,
        CMD_CANCEL   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NONE_DUE = 2'd2
    } status_t;

    // One command as held in the input register
    typedef struct packed {
        command_t               command;
        logic [ACTION_ID_W-1:0] action_id;
        logic [DELAY_W-1:0]     delay;
    } item_t;

    // One result as held in the output register
    typedef struct packed {
        status_t                status;
        logic [SLOT_W-1:0]      slot;
        logic [ACTION_ID_W-1:0] fired_action;
        logic [MASK_W-1:0]      armed_slots;
        logic [MASK_W-1:0]      due_slots;
        logic [NOW_W-1:0]       now_ticks;
    } result_t;

endpackage

[rtl/msas_cmd_if.sv]
// Command channel: valid/ready handshake with the command payload.
interface msas_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [msas_pkg::COMMAND_W-1:0]     command;
    logic [msas_pkg::ACTION_ID_W-1:0]   action_id;
    logic [msas_pkg::DELAY_W-1:0]       delay;

    modport source (output valid, command, action_id, delay, input ready);
    modport sink   (input valid, command, action_id, delay, output ready);
endinterface

[rtl/msas_rsp_if.sv]
// Result channel: valid/ready handshake with the result payload.
interface msas_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [msas_pkg::STATUS_W-1:0]      status;
    logic [msas_pkg::SLOT_W-1:0]        slot;
    logic [msas_pkg::ACTION_ID_W-1:0]   fired_action;
    logic [msas_pkg::MASK_W-1:0]        armed_slots;
    logic [msas_pkg::MASK_W-1:0]        due_slots;
    logic [msas_pkg::NOW_W-1:0]         now_ticks;

    modport source (output valid, status, slot, fired_action, armed_slots, due_slots,
                    now_ticks, input ready);
    modport sink   (input valid, status, slot, fired_action, armed_slots, due_slots,
                    now_ticks, output ready);
endinterface

[rtl/msas_in_stage.sv]
// Input register: captures one command transfer and holds it until processed.
module msas_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    msas_cmd_if.sink          req,
    input  logic              pop,
    output logic              item_valid,
    output msas_pkg::item_t   item
);

    logic            valid_reg;
    logic            valid_next;
    msas_pkg::item_t item_reg;
    logic            take;

    // Free when empty or emptied this cycle
    assign req.ready = !valid_reg || pop;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command   <= msas_pkg::command_t'(req.command);
            item_reg.action_id <= req.action_id;
            item_reg.delay     <= req.delay;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/msas_table.sv]
// Alarm table: slot state, tick counter and the single-pass command logic.
module msas_table #(
    parameter int SLOTS       = msas_pkg::DEFAULT_SLOTS,
    parameter int ACTION_BITS = msas_pkg::DEFAULT_ACTION_BITS,
    parameter int TIME_BITS   = msas_pkg::DEFAULT_TIME_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  msas_pkg::item_t   item,
    output msas_pkg::result_t result
);

    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [TIME_BITS-1:0]   time_reg;
    logic [TIME_BITS-1:0]   time_next;
    logic [SLOTS-1:0]       armed_reg;
    logic [SLOTS-1:0]       armed_next;
    logic [SLOTS-1:0]       due_reg;
    logic [SLOTS-1:0]       due_next;

    logic [TIME_BITS-1:0]   deadline_mem [SLOTS];
    logic [ACTION_BITS-1:0] action_mem   [SLOTS];

    logic [ACTION_BITS-1:0] act_in;
    logic [TIME_BITS-1:0]   dly_in;

    logic [SLOTS-1:0]       free_mask;
    logic [SLOTS-1:0]       free_oh;
    logic [SLOTS-1:0]       due_oh;
    logic [SIDX_W-1:0]      free_idx;
    logic [SIDX_W-1:0]      due_idx;
    logic [SLOTS-1:0]       cancel_hit;
    logic [SLOTS-1:0]       tick_hit;

    logic                   wr_en;
    msas_pkg::status_t      status;
    logic [SIDX_W-1:0]      slot_idx;
    logic [ACTION_BITS-1:0] fired;

    // Resize the fixed-width fields to the table's widths
    assign act_in = ACTION_BITS'(16'(item.action_id));
    assign dly_in = TIME_BITS'(64'(item.delay));

    // Lowest free slot and lowest due slot as one-hot masks
    assign free_mask = ~armed_reg;
    assign free_oh   = free_mask & ((~free_mask) + SLOTS'(1));
    assign due_oh    = due_reg & ((~due_reg) + SLOTS'(1));

    always_comb
    begin
        free_idx = '0;
        due_idx  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (free_oh[i])
            begin
                free_idx = free_idx | SIDX_W'(i);
            end
            if (due_oh[i])
            begin
                due_idx = due_idx | SIDX_W'(i);
            end
        end
    end

    // Per-slot matches for cancel and tick
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            cancel_hit[i] = armed_reg[i] && (action_mem[i] == act_in);
            tick_hit[i]   = armed_reg[i] && (deadline_mem[i] == time_reg);
        end
    end

    // Command decode and next state
    always_comb
    begin
        armed_next = armed_reg;
        due_next   = due_reg;
        time_next  = time_reg;
        wr_en      = 1'b0;
        status     = msas_pkg::ST_DONE;
        slot_idx   = '0;
        fired      = '0;
        unique case (item.command)
            msas_pkg::CMD_SCHEDULE:
            begin
                if (|free_mask)
                begin
                    armed_next = armed_reg | free_oh;
                    due_next   = due_reg & ~free_oh;
                    wr_en      = 1'b1;
                    slot_idx   = free_idx;
                end
                else
                begin
                    status = msas_pkg::ST_FULL;
                end
            end
            msas_pkg::CMD_CANCEL:
            begin
                armed_next = armed_reg & ~cancel_hit;
                due_next   = due_reg & ~cancel_hit;
            end
            msas_pkg::CMD_TICK:
            begin
                due_next  = due_reg | tick_hit;
                time_next = time_reg + TIME_BITS'(1);
            end
            msas_pkg::CMD_DISPATCH:
            begin
                if (|due_reg)
                begin
                    armed_next = armed_reg & ~due_oh;
                    due_next   = due_reg & ~due_oh;
                    slot_idx   = due_idx;
                    fired      = action_mem[due_idx];
                end
                else
                begin
                    status = msas_pkg::ST_NONE_DUE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            armed_reg <= '0;
            due_reg   <= '0;
        end
        else if (fire)
        begin
            time_reg  <= time_next;
            armed_reg <= armed_next;
            due_reg   <= due_next;
        end
    end

    // Slot contents, written when a slot is armed
    always_ff @(posedge clk)
    begin
        if (fire && wr_en)
        begin
            deadline_mem[free_idx] <= time_reg + dly_in;
            action_mem[free_idx]   <= act_in;
        end
    end

    // Result fields, state after the step
    always_comb
    begin
        result.status       = status;
        result.slot         = msas_pkg::SLOT_W'(8'(slot_idx));
        result.fired_action = msas_pkg::ACTION_ID_W'(16'(fired));
        result.armed_slots  = msas_pkg::MASK_W'(32'(armed_next));
        result.due_slots    = msas_pkg::MASK_W'(32'(due_next));
        result.now_ticks    = msas_pkg::NOW_W'(64'(time_next));
    end

endmodule

[rtl/msas_out_stage.sv]
// Output register: holds one result until the result transfer completes.
module msas_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  msas_pkg::result_t result,
    output logic              can_take,
    msas_rsp_if.source        rsp
);

    logic              valid_reg;
    logic              valid_next;
    msas_pkg::result_t result_reg;

    assign can_take = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.status       = result_reg.status;
    assign rsp.slot         = result_reg.slot;
    assign rsp.fired_action = result_reg.fired_action;
    assign rsp.armed_slots  = result_reg.armed_slots;
    assign rsp.due_slots    = result_reg.due_slots;
    assign rsp.now_ticks    = result_reg.now_ticks;

endmodule

[rtl/multi_slot_alarm_scheduler_core.sv]
// Top level of the multi-slot alarm scheduler.
//
//  channel | direction | payload                                              | one transfer
//  --------+-----------+------------------------------------------------------+-------------
//  req     | in        | command, action_id, delay                            | one command
//  rsp     | out       | status, slot, fired_action, armed_slots, due_slots,  | one result
//          |           | now_ticks                                            |
//
//  Every command gives exactly one result: it waits in the input register, then goes
//  through the table logic into the result register. A command per cycle is sustained
//  while rsp does not stall; the table updates all slots in one pass.
//  rst_n clears the tick counter and the armed and due masks; no clearing pass.
//  A stalled result holds the table; the input register still takes one command.
module multi_slot_alarm_scheduler_core #(
    parameter int SLOTS       = msas_pkg::DEFAULT_SLOTS,
    parameter int ACTION_BITS = msas_pkg::DEFAULT_ACTION_BITS,
    parameter int TIME_BITS   = msas_pkg::DEFAULT_TIME_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    msas_cmd_if.sink    req,
    msas_rsp_if.source  rsp
);

    logic              item_valid;
    msas_pkg::item_t   item;
    msas_pkg::result_t result;
    logic              can_take;
    logic              fire;

    // Process the held command when the result register is free
    assign fire = item_valid && can_take;

    msas_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pop        (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    msas_table #(
        .SLOTS       (SLOTS),
        .ACTION_BITS (ACTION_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    msas_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire),
        .result   (result),
        .can_take (can_take),
        .rsp      (rsp)
    );

endmodule

[rtl/msas_checker.sv]
// Port-level checks on the scheduler's result channel, bound to the top level.
module msas_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             ready,
    input logic [msas_pkg::STATUS_W-1:0]    status,
    input logic [msas_pkg::SLOT_W-1:0]      slot,
    input logic [msas_pkg::ACTION_ID_W-1:0] fired_action,
    input logic [msas_pkg::MASK_W-1:0]      armed_slots,
    input logic [msas_pkg::MASK_W-1:0]      due_slots,
    input logic [msas_pkg::NOW_W-1:0]       now_ticks
);

    // A stalled result holds its status, slot, fired action and tick count still
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(status) && $stable(slot)
            && $stable(fired_action) && $stable(now_ticks))
        else $error("result changed while stalled");

    // A slot is only due while armed
    a_due_armed: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (due_slots & ~armed_slots) == '0)
        else $error("due slot not armed");

    // Empty dispatch reports nothing due and hands out nothing
    a_none_due: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == msas_pkg::ST_NONE_DUE) |->
            (due_slots == '0) && (fired_action == '0) && (slot == '0))
        else $error("inconsistent empty dispatch");

    // Dropped schedule hands out nothing and names no slot
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == msas_pkg::ST_FULL) |->
            (fired_action == '0) && (slot == '0))
        else $error("inconsistent full report");

endmodule

bind multi_slot_alarm_scheduler_core msas_checker u_msas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (rsp.valid),
    .ready        (rsp.ready),
    .status       (rsp.status),
    .slot         (rsp.slot),
    .fired_action (rsp.fired_action),
    .armed_slots  (rsp.armed_slots),
    .due_slots    (rsp.due_slots),
    .now_ticks    (rsp.now_ticks)
);

[verif/multi_slot_alarm_scheduler_core_tb.sv]
// Self-checking testbench for the multi-slot alarm scheduler core.
`timescale 1ns / 100ps

module multi_slot_alarm_scheduler_core_tb;

    localparam int TABLE_SLOTS  = msas_pkg::DEFAULT_SLOTS;
    localparam int RANDOM_ITEMS = 650;
    localparam msas_pkg::result_t NO_REPLY = '0;

    // One row of the directed table: command, and optionally the typed-in reply
    typedef struct packed {
        msas_pkg::command_t               command;
        logic [msas_pkg::ACTION_ID_W-1:0] action_id;
        logic [msas_pkg::DELAY_W-1:0]     delay;
        logic                             typed;
        msas_pkg::result_t                reply;
    } stim_row_t;

    logic clk;
    logic rst_n;

    msas_cmd_if req_ch ();
    msas_rsp_if rsp_ch ();

    multi_slot_alarm_scheduler_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted alarm table
    logic [msas_pkg::NOW_W-1:0]       tick_now;
    logic [msas_pkg::MASK_W-1:0]      armed_q;
    logic [msas_pkg::MASK_W-1:0]      due_q;
    logic [msas_pkg::NOW_W-1:0]       deadline_q [TABLE_SLOTS];
    logic [msas_pkg::ACTION_ID_W-1:0] owner_q    [TABLE_SLOTS];

    msas_pkg::result_t scheduler_replies [$];
    stim_row_t         directed_rows [$];
    int                fault_count = 0;
    int                burst_left  = 0;

    // Run statistics
    int n_armed = 0, n_full = 0, n_fired = 0, n_idle_dispatch = 0;
    int n_ticks = 0, n_cancels = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the predicted table and return the reply it yields
    function automatic msas_pkg::result_t advance_alarm_table(
        msas_pkg::command_t c, logic [msas_pkg::ACTION_ID_W-1:0] a,
        logic [msas_pkg::DELAY_W-1:0] d);
        msas_pkg::result_t r;
        logic              hit;
        r   = NO_REPLY;
        hit = 1'b0;
        case (c)
            msas_pkg::CMD_SCHEDULE:
            begin
                r.status = msas_pkg::ST_FULL;
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    if (!hit && !armed_q[s])
                    begin
                        hit           = 1'b1;
                        armed_q[s]    = 1'b1;
                        due_q[s]      = 1'b0;
                        deadline_q[s] = tick_now + d;
                        owner_q[s]    = a;
                        r.status      = msas_pkg::ST_DONE;
                        r.slot        = msas_pkg::SLOT_W'(s);
                    end
                end
            end
            msas_pkg::CMD_CANCEL:
            begin
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    if (armed_q[s] && owner_q[s] == a)
                    begin
                        armed_q[s] = 1'b0;
                        due_q[s]   = 1'b0;
                    end
                end
            end
            msas_pkg::CMD_TICK:
            begin
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    if (armed_q[s] && deadline_q[s] == tick_now)
                        due_q[s] = 1'b1;
                end
                tick_now = tick_now + 1'b1;
            end
            default:
            begin
                r.status = msas_pkg::ST_NONE_DUE;
                for (int s = 0; s < TABLE_SLOTS; s++)
                begin
                    if (!hit && due_q[s])
                    begin
                        hit            = 1'b1;
                        r.fired_action = owner_q[s];
                        armed_q[s]     = 1'b0;
                        due_q[s]       = 1'b0;
                        r.status       = msas_pkg::ST_DONE;
                        r.slot         = msas_pkg::SLOT_W'(s);
                    end
                end
            end
        endcase
        r.armed_slots = armed_q;
        r.due_slots   = due_q;
        r.now_ticks   = tick_now;
        return r;
    endfunction

    // Drive one command in bursts with random gaps; predict on transfer
    task automatic issue_command(input msas_pkg::command_t c,
                                 input logic [msas_pkg::ACTION_ID_W-1:0] a,
                                 input logic [msas_pkg::DELAY_W-1:0] d, input logic typed,
                                 input msas_pkg::result_t typed_reply);
        msas_pkg::result_t predicted;
        int                gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.command   <= c;
        req_ch.action_id <= a;
        req_ch.delay     <= d;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);

        predicted = advance_alarm_table(c, a, d);
        case (c)
            msas_pkg::CMD_SCHEDULE:
                if (predicted.status == msas_pkg::ST_FULL) n_full++; else n_armed++;
            msas_pkg::CMD_CANCEL: n_cancels++;
            msas_pkg::CMD_TICK:   n_ticks++;
            default:
                if (predicted.status == msas_pkg::ST_DONE) n_fired++; else n_idle_dispatch++;
        endcase
        scheduler_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic report_field(input string name, input logic [msas_pkg::NOW_W-1:0] exp_v,
                                input logic [msas_pkg::NOW_W-1:0] got_v);
        if (exp_v !== got_v)
        begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    // Result monitor: every transfer against the oldest prediction
    initial
    begin
        msas_pkg::result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (scheduler_replies.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, got status %0h",
                             $time, rsp_ch.status);
                end
                else
                begin
                    exp_r = scheduler_replies.pop_front();
                    report_field("status", msas_pkg::NOW_W'(exp_r.status),
                                 msas_pkg::NOW_W'(rsp_ch.status));
                    report_field("slot", msas_pkg::NOW_W'(exp_r.slot),
                                 msas_pkg::NOW_W'(rsp_ch.slot));
                    report_field("fired_action", msas_pkg::NOW_W'(exp_r.fired_action),
                                 msas_pkg::NOW_W'(rsp_ch.fired_action));
                    report_field("armed_slots", msas_pkg::NOW_W'(exp_r.armed_slots),
                                 msas_pkg::NOW_W'(rsp_ch.armed_slots));
                    report_field("due_slots", msas_pkg::NOW_W'(exp_r.due_slots),
                                 msas_pkg::NOW_W'(rsp_ch.due_slots));
                    report_field("now_ticks", exp_r.now_ticks, rsp_ch.now_ticks);
                end
            end
        end
    end

    // Receiver: stall pattern changes mode every so often
    initial
    begin
        int phase;
        int mode;
        phase = 0;
        mode  = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase++;
            if (phase % 48 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_ch.ready <= (phase % 4 == 0);
                default: rsp_ch.ready <= ((phase % 16) < 3);
            endcase
        end
    end

    // Stimulus
    initial
    begin
        msas_pkg::command_t               c;
        logic [msas_pkg::ACTION_ID_W-1:0] a;
        logic [msas_pkg::DELAY_W-1:0]     d;
        int                               pick;

        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.command   <= msas_pkg::CMD_SCHEDULE;
        req_ch.action_id <= '0;
        req_ch.delay     <= '0;

        tick_now = '0;
        armed_q  = '0;
        due_q    = '0;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            deadline_q[s] = '0;
            owner_q[s]    = '0;
        end

        // Directed rows: empty table, wrapped deadline, full table, cancels, dispatch order
        directed_rows.push_back({msas_pkg::CMD_DISPATCH, 8'h00, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_NONE_DUE, 3'd0, 8'h00, 8'h00, 8'h00, 32'd0});
        directed_rows.push_back({msas_pkg::CMD_TICK, 8'h00, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_DONE, 3'd0, 8'h00, 8'h00, 8'h00, 32'd1});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'hFF, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_DONE, 3'd0, 8'h00, 8'h01, 8'h00, 32'd1});
        directed_rows.push_back({msas_pkg::CMD_TICK, 8'h00, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_DONE, 3'd0, 8'h00, 8'h01, 8'h01, 32'd2});
        directed_rows.push_back({msas_pkg::CMD_DISPATCH, 8'h00, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_DONE, 3'd0, 8'hFF, 8'h00, 8'h00, 32'd2});
        // deadline wraps round to a time already gone
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h00, 32'hFFFF_FFFF, 1'b1,
                                 msas_pkg::ST_DONE, 3'd0, 8'h00, 8'h01, 8'h00, 32'd2});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h55, 32'h0000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'hAA, 32'h0000_0001, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h80, 32'h8000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h01, 32'h7FFF_FFFF, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'hAA, 32'h0000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h7F, 32'h0000_0002, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'hFE, 32'hFFFF_FFFE, 1'b0, NO_REPLY});
        // table full: request dropped
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h12, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_FULL, 3'd0, 8'h00, 8'hFF, 8'h00, 32'd2});
        directed_rows.push_back({msas_pkg::CMD_CANCEL, 8'h33, 32'h0000_0000, 1'b1,
                                 msas_pkg::ST_DONE, 3'd0, 8'h00, 8'hFF, 8'h00, 32'd2});
        directed_rows.push_back({msas_pkg::CMD_TICK, 8'h00, 32'h0000_0000, 1'b0, NO_REPLY});
        // cancel hits two slots, one of them already due
        directed_rows.push_back({msas_pkg::CMD_CANCEL, 8'hAA, 32'h0000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_SCHEDULE, 8'h3C, 32'h0000_0005, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_TICK, 8'h00, 32'h0000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_DISPATCH, 8'h00, 32'h0000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_DISPATCH, 8'hFF, 32'hFFFF_FFFF, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_DISPATCH, 8'h00, 32'h0000_0000, 1'b0, NO_REPLY});
        directed_rows.push_back({msas_pkg::CMD_CANCEL, 8'h00, 32'h0000_0000, 1'b0, NO_REPLY});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_command(directed_rows[i].command, directed_rows[i].action_id,
                          directed_rows[i].delay, directed_rows[i].typed,
                          directed_rows[i].reply);

        // Random commands: small action pool so cancels match, mostly short delays
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                c = msas_pkg::CMD_SCHEDULE;
            else if (pick < 62)
                c = msas_pkg::CMD_TICK;
            else if (pick < 88)
                c = msas_pkg::CMD_DISPATCH;
            else
                c = msas_pkg::CMD_CANCEL;

            a = ($urandom_range(0, 4) != 0) ? msas_pkg::ACTION_ID_W'($urandom_range(0, 5))
                                            : msas_pkg::ACTION_ID_W'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                d = msas_pkg::DELAY_W'($urandom_range(0, 8));
            else if (pick < 85)
                d = $urandom();
            else
                d = 32'hFFFF_FFF0 + msas_pkg::DELAY_W'($urandom_range(0, 15));

            issue_command(c, a, d, 1'b0, NO_REPLY);
        end
        req_ch.valid <= 1'b0;

        // Drain, then let the two-stage pipeline settle
        while (scheduler_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d schedules armed, %0d dropped as full, %0d cancels, %0d ticks",
                 n_armed, n_full, n_cancels, n_ticks);
        $display("Dispatch fired %0d actions and found nothing due %0d times",
                 n_fired, n_idle_dispatch);
        if (fault_count == 0 && scheduler_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", scheduler_replies.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
rtl/msas_pkg.sv
rtl/msas_cmd_if.sv
rtl/msas_rsp_if.sv
rtl/msas_in_stage.sv
rtl/msas_table.sv
rtl/msas_out_stage.sv
rtl/multi_slot_alarm_scheduler_core.sv
rtl/msas_checker.sv
verif/multi_slot_alarm_scheduler_core_tb.sv
